### src/cre_pkg.sv
// Shared types and constants for the combination rank encoder.
package cre_pkg;

	localparam int RANK_W    = 61;
	localparam int COUNT_W   = 7;
	localparam int ORB_W     = 6;
	localparam int ROM_ROWS  = 64;
	localparam int ROM_COLS  = 65;
	localparam int ROM_DEPTH = ROM_ROWS * ROM_COLS;
	localparam int ADDR_W    = $clog2(ROM_DEPTH);
	localparam int COUNT_MAX = 127;

	typedef enum logic {
		MODE_LIST   = 1'b0,
		MODE_BITMAP = 1'b1
	} mode_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [RANK_W-1:0] data;
	} rom_wr_t;

endpackage

### src/cre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cre_ram #(
	parameter int WIDTH = 61,
	parameter int DEPTH = 4160
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### src/cre_fill.sv
// Builds the Pascal triangle into the binomial RAM after reset, one entry per cycle.
module cre_fill
	import cre_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	output logic    busy,
	output rom_wr_t wr
);

	logic              busy_q;
	logic [ORB_W-1:0]  m_q;
	logic [COUNT_W-1:0] n_q;
	logic [ADDR_W-1:0] addr_q;
	logic [RANK_W-1:0] carry_q;
	logic [RANK_W-1:0] row_q [ROM_COLS];
	logic [RANK_W-1:0] head;
	logic [RANK_W-1:0] value;
	logic              row_end;

	// row_q rotates once per triangle row; new C(m,n) = C(m-1,n) + C(m-1,n-1)
	assign head    = row_q[0];
	assign row_end = (n_q == COUNT_W'(ROM_COLS - 1));

	always_comb begin
		if (m_q == '0) begin
			value = (n_q == '0) ? RANK_W'(1) : '0;
		end else begin
			value = head + carry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			m_q     <= '0;
			n_q     <= '0;
			addr_q  <= '0;
			carry_q <= '0;
		end else if (busy_q) begin
			addr_q <= addr_q + ADDR_W'(1);
			if (row_end) begin
				n_q     <= '0;
				m_q     <= m_q + ORB_W'(1);
				carry_q <= '0;
				if (m_q == ORB_W'(ROM_ROWS - 1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				n_q     <= n_q + COUNT_W'(1);
				carry_q <= head;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int i = 0; i < ROM_COLS - 1; i++) begin
				row_q[i] <= row_q[i+1];
			end
			row_q[ROM_COLS-1] <= value;
		end
	end

	assign busy    = busy_q;
	assign wr.en   = busy_q;
	assign wr.addr = addr_q;
	assign wr.data = value;

endmodule

### src/combination_rank_encoder.sv
// Combination rank encoder top level: occupation stream in, combinatorial rank out.
// Throughput: one request per cycle after the table build, unless a finished result is held by out_stall.
// A result is presented on out_valid once its last request has passed stage 1 and the result register.
// Stage 1 updates the particle count and reads C(c,k) from the RAM; stage 2 accumulates.
// Reset: state clears and the binomial RAM (4160 entries) is rebuilt with in_stall high.
// mode_q resets to list mode; cfg_wr_en is taken at any time.
module combination_rank_encoder
	import cre_pkg::*;
#(
	parameter int NUM_ORBITALS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ORB_W-1:0]  orbital,
	input  logic              occupied,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RANK_W-1:0] rank,
	output logic [COUNT_W-1:0] particles,
	output logic              order_error
);

	localparam logic [COUNT_W-1:0] NUM_ORB = COUNT_W'(NUM_ORBITALS);

	mode_t              mode_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] pos_q;
	logic [ORB_W-1:0]   prev_q;
	logic               seen_q;
	logic               err_q;

	logic               valid_s1;
	logic               last_s1;
	logic               add_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               err_s1;

	logic [RANK_W-1:0]  acc_q;
	logic               out_valid_q;
	logic [RANK_W-1:0]  res_rank_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_err_q;

	logic               fill_busy;
	rom_wr_t            fill_wr;
	logic [RANK_W-1:0]  rom_data;

	logic               advance;
	logic               accept;
	logic               take;
	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] count_nx;
	logic [COUNT_W-1:0] pos_nx;
	logic               err_nx;
	logic               add_nx;
	logic [ORB_W-1:0]   col;
	logic [ADDR_W-1:0]  rd_addr;
	logic [RANK_W-1:0]  sum;

	cre_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (fill_busy),
		.wr     (fill_wr)
	);

	cre_ram #(
		.WIDTH (RANK_W),
		.DEPTH (ROM_DEPTH)
	) u_rom (
		.clk     (clk),
		.wr_en   (fill_wr.en),
		.wr_addr (fill_wr.addr),
		.wr_data (fill_wr.data),
		.rd_en   (advance),
		.rd_addr (rd_addr),
		.rd_data (rom_data)
	);

	// stage 1 may move unless it holds a finished pattern that cannot be handed off
	assign advance  = !valid_s1 || !last_s1 || !out_valid_q || !out_stall;
	assign in_stall = fill_busy || !advance;
	assign accept   = in_valid && !in_stall;
	assign take     = valid_s1 && advance;

	assign count_inc = (count_q == COUNT_W'(COUNT_MAX)) ? count_q : count_q + COUNT_W'(1);

	always_comb begin
		count_nx = count_q;
		pos_nx   = pos_q;
		err_nx   = err_q;
		add_nx   = 1'b0;
		col      = orbital;
		if (mode_q == MODE_LIST) begin
			if ((seen_q && orbital <= prev_q) || ({1'b0, orbital} >= NUM_ORB)) begin
				err_nx = 1'b1;
			end
			count_nx = count_inc;
			add_nx   = 1'b1;
		end else begin
			col = pos_q[ORB_W-1:0];
			if (pos_q >= NUM_ORB) begin
				err_nx = 1'b1;
			end else begin
				pos_nx = pos_q + COUNT_W'(1);
				if (occupied) begin
					count_nx = count_inc;
					add_nx   = 1'b1;
				end
			end
		end
	end

	// C(c,k) with k beyond the last column is not added: add_s1 masks that read
	assign rd_addr = ADDR_W'(col) * ADDR_W'(ROM_COLS) + ADDR_W'(count_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LIST;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			prev_q  <= '0;
			seen_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				pos_q   <= '0;
				prev_q  <= '0;
				seen_q  <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				pos_q   <= pos_nx;
				err_q   <= err_nx;
				if (mode_q == MODE_LIST) begin
					prev_q <= orbital;
					seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= last;
			add_s1   <= add_nx && (count_nx <= COUNT_W'(ROM_COLS - 1));
			count_s1 <= count_nx;
			err_s1   <= err_nx;
		end
	end

	assign sum = acc_q + (add_s1 ? rom_data : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= last_s1 ? '0 : sum;
			end
			if (take && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			res_rank_q  <= sum;
			res_count_q <= count_s1;
			res_err_q   <= err_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign rank        = res_rank_q;
	assign particles   = res_count_q;
	assign order_error = res_err_q;

	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy |-> in_stall)
		else $error("request accepted during table build");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(last_s1) && $stable(count_s1)))
		else $error("stage 1 lost a blocked request");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without a finished pattern");

	a_build_blocks_output: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy |-> (!valid_s1 && !out_valid_q))
		else $error("pipeline active during table build");

endmodule
